// File: rtl/ppmcd_pkg.sv
// shared constants and types for the ppm channel decoder
`default_nettype none
package ppmcd_pkg;

    localparam int NUM_CHANNELS = 10;
    localparam int TIME_W       = 16;
    localparam int WIDTH_W      = TIME_W + 1;
    localparam int OFFSET_W     = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int SLOT_IDX_W   = 4;
    localparam int SLOT_CNT_W   = $clog2(NUM_CHANNELS + 1);
    localparam int SLOT_ADR_W   = $clog2(NUM_CHANNELS);

    localparam logic [TIME_W-1:0]   SYNC_THRESHOLD_RST   = 16'd2500;
    localparam logic [OFFSET_W-1:0] WIDTH_OFFSET_RST     = 8'd25;
    localparam logic [TIME_W-1:0]   STICK_MINIMUM_RST    = 16'd990;
    localparam logic [TIME_W-1:0]   THROTTLE_MINIMUM_RST = 16'd800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_THRESHOLD   = 2'd0,
        CFG_WIDTH_OFFSET     = 2'd1,
        CFG_STICK_MINIMUM    = 2'd2,
        CFG_THROTTLE_MINIMUM = 2'd3
    } t_cfg_reg;

    // request from the top level into the slot bank
    typedef struct packed {
        logic              valid;
        logic              frame;
        logic [TIME_W-1:0] value;
    } t_slot_req;

    // slot bank outcome for the current request
    typedef struct packed {
        logic                  written;
        logic [SLOT_IDX_W-1:0] index;
        logic                  sticks_ready;
    } t_slot_rsp;

endpackage
`default_nettype wire

// File: rtl/ppmcd_slot_bank.sv
// channel slot counter, slot store and stick readiness check
`default_nettype none
module ppmcd_slot_bank
    import ppmcd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [TIME_W-1:0] i_stick_minimum,
    input  wire logic [TIME_W-1:0] i_throttle_minimum,
    input  wire t_slot_req         i_req,
    output t_slot_rsp              o_rsp
);

    logic [SLOT_CNT_W-1:0] r_count, n_count;
    logic [TIME_W-1:0]     r_slot [NUM_CHANNELS];
    logic [TIME_W-1:0]     n_slot [NUM_CHANNELS];
    logic                  wr_en;

    always_comb begin
        wr_en   = i_req.valid && !i_req.frame &&
                  (r_count < SLOT_CNT_W'(NUM_CHANNELS));
        n_count = r_count;
        if (i_req.valid) begin
            if (i_req.frame) begin
                n_count = '0;
            end else if (wr_en) begin
                n_count = r_count + SLOT_CNT_W'(1);
            end
        end
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            n_slot[k] = r_slot[k];
            if (wr_en && (r_count[SLOT_ADR_W-1:0] == SLOT_ADR_W'(k))) begin
                n_slot[k] = i_req.value;
            end
        end
        o_rsp.written      = wr_en;
        o_rsp.index        = wr_en ? SLOT_IDX_W'(r_count) : '0;
        // readiness seen after this edge's write
        o_rsp.sticks_ready = (n_slot[0] >= i_stick_minimum) &&
                             (n_slot[1] >= i_stick_minimum) &&
                             (n_slot[2] >= i_throttle_minimum) &&
                             (n_slot[3] >= i_stick_minimum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_slot[k] <= '0;
            end
        end else begin
            r_count <= n_count;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_slot[k] <= n_slot[k];
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/ppm_channel_decoder_core.sv
// ppm channel decoder: one capture time in, one decoded pulse result out
// output: each result is registered into the output register, or into the skid
//   entry while the consumer stalls; one capture per cycle while the skid is
//   empty, so the two-entry output keeps accepting while one result waits
// reset: synchronous active low; config returns to defaults, previous capture,
//   slot counter and all slots clear to zero
`default_nettype none
module ppm_channel_decoder_core
    import ppmcd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [TIME_W-1:0]     i_capture_time,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [WIDTH_W-1:0]  o_pulse_width,
    output logic                       o_frame_start,
    output logic                       o_slot_written,
    output logic [SLOT_IDX_W-1:0]      o_slot_index,
    output logic                       o_sticks_ready
);

    typedef struct packed {
        logic [WIDTH_W-1:0]    pulse_width;
        logic                  frame_start;
        logic                  slot_written;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic                  sticks_ready;
    } t_result;

    logic [TIME_W-1:0]   r_sync_threshold;
    logic [OFFSET_W-1:0] r_width_offset;
    logic [TIME_W-1:0]   r_stick_minimum;
    logic [TIME_W-1:0]   r_throttle_minimum;
    logic [TIME_W-1:0]   r_last_capture;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid, n_result;

    logic                      accept;
    logic [TIME_W-1:0]         interval;
    logic signed [WIDTH_W-1:0] width;
    logic                      is_sync;
    t_slot_req                 slot_req;
    t_slot_rsp                 slot_rsp;

    assign o_in_ready = !r_skid_valid;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        interval = i_capture_time - r_last_capture;
        width    = signed'({1'b0, interval}) - signed'(WIDTH_W'(r_width_offset));
        is_sync  = width > signed'({1'b0, r_sync_threshold});

        slot_req.valid = accept;
        slot_req.frame = is_sync;
        slot_req.value = width[TIME_W-1:0];

        n_result.pulse_width  = width;
        n_result.frame_start  = is_sync;
        n_result.slot_written = slot_rsp.written;
        n_result.slot_index   = slot_rsp.index;
        n_result.sticks_ready = slot_rsp.sticks_ready;
    end

    ppmcd_slot_bank u_slot_bank (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_stick_minimum    (r_stick_minimum),
        .i_throttle_minimum (r_throttle_minimum),
        .i_req              (slot_req),
        .o_rsp              (slot_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_threshold   <= SYNC_THRESHOLD_RST;
            r_width_offset     <= WIDTH_OFFSET_RST;
            r_stick_minimum    <= STICK_MINIMUM_RST;
            r_throttle_minimum <= THROTTLE_MINIMUM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SYNC_THRESHOLD:   r_sync_threshold   <= i_cfg_data;
                CFG_WIDTH_OFFSET:     r_width_offset     <= i_cfg_data[OFFSET_W-1:0];
                CFG_STICK_MINIMUM:    r_stick_minimum    <= i_cfg_data;
                CFG_THROTTLE_MINIMUM: r_throttle_minimum <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_capture <= '0;
        end else if (accept) begin
            r_last_capture <= i_capture_time;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || i_out_ready) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= accept;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_result;
            end
        end else if (accept) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pulse_width  = signed'(r_out.pulse_width);
    assign o_frame_start  = r_out.frame_start;
    assign o_slot_written = r_out.slot_written;
    assign o_slot_index   = r_out.slot_index;
    assign o_sticks_ready = r_out.sticks_ready;

endmodule
`default_nettype wire
